### design/ccpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpf_pkg
// shared word types, widths and constants of the circle contact force block
// ----------------------------------------------------------------------------
`default_nettype none

package ccpf_pkg;

   localparam int ROOT_W = 25;            // centre distance, q.8
   localparam int RAD_W  = 2 * ROOT_W;    // squared distance, q.16
   localparam int DIFF_W = 18;            // centre delta while in contact
   localparam int RSUM_W = 17;
   localparam int QUO_W  = 26;            // force magnitude per axis
   localparam int NUM_W  = ROOT_W + QUO_W + 1;
   localparam logic [15:0] STIFF_RESET = 16'd19005;

   typedef struct packed {
      logic signed [23:0] a_x;
      logic signed [23:0] a_y;
      logic [15:0]        a_radius;
      logic               a_fixed;
      logic signed [23:0] b_x;
      logic signed [23:0] b_y;
      logic [15:0]        b_radius;
      logic               b_fixed;
   } req_word_type;

   typedef struct packed {
      logic               contact;
      logic signed [31:0] force_a_x;
      logic signed [31:0] force_a_y;
      logic signed [31:0] force_b_x;
      logic signed [31:0] force_b_y;
   } rsp_word_type;

   // pair info riding along the root pipeline
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [RSUM_W-1:0]        rsum;
      logic [15:0]              rmin;
      logic                     afix;
      logic                     bfix;
      logic                     live;
      logic                     contact;
   } root_meta_type;

   // pair info riding along the divider pipeline
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic afix;
      logic bfix;
      logic live;
      logic contact;
   } div_meta_type;

endpackage

`default_nettype wire

### design/circle_contact_penalty_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_contact_penalty_force
// penalty contact force between two circles, fully pipelined
//
//   port group   dir   handshake          word
//   req_*        in    req_valid/ready    req_word_type
//   rsp_*        out   rsp_valid/ready    rsp_word_type
//   csr_*        in    csr_wr_en          16-bit stiffness
//
// one pair per cycle sustained while the output is not stalled; accept to rsp_valid:
// 3 front stages, 25 root stages, 6 magnitude stages, 26 divider stages, out
// the whole pipe advances when the output register is empty or being taken
// synchronous reset clears all valid bits and loads the default stiffness
// ----------------------------------------------------------------------------
`default_nettype none

module circle_contact_penalty_force
   import ccpf_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_word_type   req_word,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_word_type        rsp_word,
   input  wire logic           csr_wr_en,
   input  wire logic [15:0]    csr_wr_data
);

   logic en;
   logic [15:0] stiff_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_word_ff, rsp_word_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stiff_ff <= STIFF_RESET;
      end else if (csr_wr_en) begin
         stiff_ff <= csr_wr_data;
      end
   end

   // front: deltas, radius sum, squares, contact test
   logic v1_ff, v2_ff, v3_ff;
   logic signed [24:0] dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic [RSUM_W-1:0] rs1_ff, rs2_ff;
   logic [15:0] mn1_ff, mn2_ff;
   logic af1_ff, bf1_ff, af2_ff, bf2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff;
   logic signed [49:0] sqx, sqy;
   logic [48:0] sqx_ff, sqy_ff;
   logic [33:0] rsq_ff;
   logic [49:0] d2;
   logic [RAD_W-1:0] rad3_ff, rad3_in;
   root_meta_type meta3_ff, meta3_in;

   assign dx1_in = 25'(req_word.a_x) - 25'(req_word.b_x);
   assign dy1_in = 25'(req_word.a_y) - 25'(req_word.b_y);
   assign sqx    = dx1_ff * dx1_ff;
   assign sqy    = dy1_ff * dy1_ff;
   assign d2     = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      meta3_in.dx      = dx2_ff;
      meta3_in.dy      = dy2_ff;
      meta3_in.rsum    = rs2_ff;
      meta3_in.rmin    = mn2_ff;
      meta3_in.afix    = af2_ff;
      meta3_in.bfix    = bf2_ff;
      meta3_in.contact = d2 < {16'd0, rsq_ff};
      meta3_in.live    = meta3_in.contact && (d2 != '0);
      rad3_in          = meta3_in.contact ? {d2[33:0], 16'd0} : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= dx1_in;
         dy1_ff   <= dy1_in;
         rs1_ff   <= 17'(req_word.a_radius) + 17'(req_word.b_radius);
         mn1_ff   <= (req_word.a_radius < req_word.b_radius) ?
                     req_word.a_radius : req_word.b_radius;
         af1_ff   <= req_word.a_fixed;
         bf1_ff   <= req_word.b_fixed;
         sqx_ff   <= sqx[48:0];
         sqy_ff   <= sqy[48:0];
         rsq_ff   <= 34'(rs1_ff) * 34'(rs1_ff);
         rs2_ff   <= rs1_ff;
         mn2_ff   <= mn1_ff;
         af2_ff   <= af1_ff;
         bf2_ff   <= bf1_ff;
         dx2_ff   <= dx1_ff[DIFF_W-1:0];
         dy2_ff   <= dy1_ff[DIFF_W-1:0];
         rad3_ff  <= rad3_in;
         meta3_ff <= meta3_in;
      end
   end

   // centre distance
   logic sq_valid;
   logic [ROOT_W-1:0] sq_len;
   root_meta_type sq_meta;

   ccpf_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (rad3_ff),
      .in_meta   (meta3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_len),
      .out_meta  (sq_meta)
   );

   // magnitude and numerators
   logic m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff;
   logic [ROOT_W-1:0] len1_ff, len2_ff, len3_ff, len4_ff, len5_ff, len6_ff;
   root_meta_type meta_m1_ff;
   div_meta_type dm2_ff, dm3_ff, dm4_ff, dm5_ff, dm6_ff, dm2_in;
   logic [ROOT_W-1:0] depth_ff;
   logic [15:0] mn_m2_ff;
   logic [40:0] p1_ff;
   logic [56:0] p2_ff;
   logic [57:0] rnd;
   logic [ROOT_W-1:0] mag_ff;
   logic [RSUM_W-1:0] adx2_ff, ady2_ff, adx3_ff, ady3_ff, adx4_ff, ady4_ff;
   logic [41:0] px_ff, py_ff;
   logic [NUM_W-1:0] nx_ff, ny_ff;

   always_comb begin
      dm2_in.neg_x   = meta_m1_ff.dx < 0;
      dm2_in.neg_y   = meta_m1_ff.dy < 0;
      dm2_in.afix    = meta_m1_ff.afix;
      dm2_in.bfix    = meta_m1_ff.bfix;
      dm2_in.live    = meta_m1_ff.live;
      dm2_in.contact = meta_m1_ff.contact;
   end

   assign rnd = {1'b0, p2_ff} + (58'd1 << 31);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff <= 1'b0;
         m2_ff <= 1'b0;
         m3_ff <= 1'b0;
         m4_ff <= 1'b0;
         m5_ff <= 1'b0;
         m6_ff <= 1'b0;
      end else if (en) begin
         m1_ff <= sq_valid;
         m2_ff <= m1_ff;
         m3_ff <= m2_ff;
         m4_ff <= m3_ff;
         m5_ff <= m4_ff;
         m6_ff <= m5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len1_ff    <= sq_len;
         meta_m1_ff <= sq_meta;
         depth_ff   <= {sq_meta.rsum, 8'd0} - sq_len;
         len2_ff    <= len1_ff;
         dm2_ff     <= dm2_in;
         p1_ff      <= 41'(depth_ff) * 41'(stiff_ff);
         mn_m2_ff   <= meta_m1_ff.rmin;
         adx2_ff    <= dm2_in.neg_x ? RSUM_W'(-meta_m1_ff.dx) : RSUM_W'(meta_m1_ff.dx);
         ady2_ff    <= dm2_in.neg_y ? RSUM_W'(-meta_m1_ff.dy) : RSUM_W'(meta_m1_ff.dy);
         len3_ff    <= len2_ff;
         dm3_ff     <= dm2_ff;
         p2_ff      <= 57'(p1_ff) * 57'(mn_m2_ff);
         adx3_ff    <= adx2_ff;
         ady3_ff    <= ady2_ff;
         len4_ff    <= len3_ff;
         dm4_ff     <= dm3_ff;
         mag_ff     <= rnd[56:32];
         adx4_ff    <= adx3_ff;
         ady4_ff    <= ady3_ff;
         len5_ff    <= len4_ff;
         dm5_ff     <= dm4_ff;
         px_ff      <= 42'(mag_ff) * 42'(adx4_ff);
         py_ff      <= 42'(mag_ff) * 42'(ady4_ff);
         len6_ff    <= len5_ff;
         dm6_ff     <= dm5_ff;
         nx_ff      <= NUM_W'({px_ff, 8'd0}) + NUM_W'(len5_ff[ROOT_W-1:1]);
         ny_ff      <= NUM_W'({py_ff, 8'd0}) + NUM_W'(len5_ff[ROOT_W-1:1]);
      end
   end

   // per-axis division by the distance
   logic dv_valid;
   logic [QUO_W-1:0] qx, qy;
   div_meta_type dv_meta;

   ccpf_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m6_ff),
      .in_num_x  (nx_ff),
      .in_num_y  (ny_ff),
      .in_den    (len6_ff),
      .in_meta   (dm6_ff),
      .out_valid (dv_valid),
      .out_quo_x (qx),
      .out_quo_y (qy),
      .out_meta  (dv_meta)
   );

   // output word
   logic [31:0] fx, fy;

   always_comb begin
      fx = dv_meta.neg_x ? -32'(qx) : 32'(qx);
      fy = dv_meta.neg_y ? -32'(qy) : 32'(qy);
      if (!dv_meta.live) begin
         fx = '0;
         fy = '0;
      end
      rsp_word_in.contact   = dv_meta.contact;
      rsp_word_in.force_a_x = dv_meta.afix ? '0 : fx;
      rsp_word_in.force_a_y = dv_meta.afix ? '0 : fy;
      rsp_word_in.force_b_x = dv_meta.bfix ? '0 : -fx;
      rsp_word_in.force_b_y = dv_meta.bfix ? '0 : -fy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   a_no_contact_no_force : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.contact |->
         rsp_word.force_a_x == 0 && rsp_word.force_a_y == 0 &&
         rsp_word.force_b_x == 0 && rsp_word.force_b_y == 0)
      else $error("force without contact");

   a_opposite_x : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.force_a_x == 0 || rsp_word.force_b_x == 0 ||
                    rsp_word.force_a_x == -rsp_word.force_b_x)
      else $error("x forces not opposite");

   a_opposite_y : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.force_a_y == 0 || rsp_word.force_b_y == 0 ||
                    rsp_word.force_a_y == -rsp_word.force_b_y)
      else $error("y forces not opposite");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word) && !$past(req_ready))
      else $error("pipe moved while stalled");

endmodule

`default_nettype wire

### design/ccpf_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpf_sqrt_pipe
// integer square root, one root bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module ccpf_sqrt_pipe
   import ccpf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [RAD_W-1:0]    in_rad,
   input  wire root_meta_type       in_meta,
   output logic                     out_valid,
   output logic [ROOT_W-1:0]        out_root,
   output root_meta_type            out_meta
);

   localparam int N     = ROOT_W;
   localparam int REM_W = ROOT_W + 3;

   logic                valid_ff [0:N-1];
   logic [RAD_W-1:0]    rad_ff   [0:N-1];
   logic [REM_W-1:0]    rem_ff   [0:N-1];
   logic [ROOT_W-1:0]   root_ff  [0:N-1];
   root_meta_type       meta_ff  [0:N-1];

   logic [RAD_W-1:0]    rad_in   [0:N-1];
   logic [REM_W-1:0]    rem_in   [0:N-1];
   logic [ROOT_W-1:0]   root_in  [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                src_valid;
      logic [RAD_W-1:0]    src_rad;
      logic [REM_W-1:0]    src_rem;
      logic [ROOT_W-1:0]   src_root;
      root_meta_type       src_meta;
      logic [REM_W-1:0]    rem_sh;
      logic [REM_W-1:0]    trial;

      if (k == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_rad   = in_rad;
         assign src_rem   = '0;
         assign src_root  = '0;
         assign src_meta  = in_meta;
      end else begin : g_body
         assign src_valid = valid_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_root  = root_ff[k-1];
         assign src_meta  = meta_ff[k-1];
      end

      always_comb begin
         rem_sh    = {src_rem[REM_W-3:0], src_rad[RAD_W-1 -: 2]};
         trial     = {1'b0, src_root, 2'b01};
         rad_in[k] = {src_rad[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in[k]  = rem_sh - trial;
            root_in[k] = {src_root[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh;
            root_in[k] = {src_root[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            meta_ff[k] <= src_meta;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_meta  = meta_ff[N-1];

endmodule

`default_nettype wire

### design/ccpf_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccpf_div_pipe
// two-lane restoring divider sharing one divisor, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module ccpf_div_pipe
   import ccpf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [NUM_W-1:0]    in_num_x,
   input  wire logic [NUM_W-1:0]    in_num_y,
   input  wire logic [ROOT_W-1:0]   in_den,
   input  wire div_meta_type        in_meta,
   output logic                     out_valid,
   output logic [QUO_W-1:0]         out_quo_x,
   output logic [QUO_W-1:0]         out_quo_y,
   output div_meta_type             out_meta
);

   localparam int N = QUO_W;

   logic                valid_ff [0:N-1];
   logic [ROOT_W-1:0]   den_ff   [0:N-1];
   div_meta_type        meta_ff  [0:N-1];
   logic [ROOT_W-1:0]   rem_ff   [0:N-1][0:1];
   logic [QUO_W-1:0]    low_ff   [0:N-1][0:1];
   logic [ROOT_W-1:0]   rem_in   [0:N-1][0:1];
   logic [QUO_W-1:0]    low_in   [0:N-1][0:1];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic                src_valid;
      logic [ROOT_W-1:0]   src_den;
      div_meta_type        src_meta;

      if (k == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_den   = in_den;
         assign src_meta  = in_meta;
      end else begin : g_body
         assign src_valid = valid_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_meta  = meta_ff[k-1];
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [ROOT_W-1:0]   src_rem;
         logic [QUO_W-1:0]    src_low;
         logic [ROOT_W:0]     sh;
         logic [ROOT_W:0]     dif;

         if (k == 0) begin : g_head
            logic [NUM_W-1:0] num;
            assign num     = (l == 0) ? in_num_x : in_num_y;
            assign src_rem = num[NUM_W-2 -: ROOT_W];
            assign src_low = num[QUO_W-1:0];
         end else begin : g_body
            assign src_rem = rem_ff[k-1][l];
            assign src_low = low_ff[k-1][l];
         end

         always_comb begin
            sh  = {src_rem, src_low[QUO_W-1]};
            dif = sh - {1'b0, src_den};
            if (sh >= {1'b0, src_den}) begin
               rem_in[k][l] = dif[ROOT_W-1:0];
               low_in[k][l] = {src_low[QUO_W-2:0], 1'b1};
            end else begin
               rem_in[k][l] = sh[ROOT_W-1:0];
               low_in[k][l] = {src_low[QUO_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l] <= rem_in[k][l];
               low_ff[k][l] <= low_in[k][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k]  <= src_den;
            meta_ff[k] <= src_meta;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quo_x = low_ff[N-1][0];
   assign out_quo_y = low_ff[N-1][1];
   assign out_meta  = meta_ff[N-1];

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives circle pairs through circle_contact_penalty_force with random gaps
// and stalls, predicts each result word in fixed point and compares field by
// field; stiffness is rewritten between phases while the pipe is empty
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import ccpf_pkg::*;

   localparam int LATENCY = 61;

   typedef struct {
      req_word_type word;
      logic         has_expect;
      rsp_word_type expect_word;
   } stim_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   req_word_type  req_word = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_word_type  rsp_word;
   logic          csr_wr_en = 1'b0;
   logic [15:0]   csr_wr_data = '0;

   logic [15:0]   stiffness_model = STIFF_RESET;
   rsp_word_type  force_queue[$];
   int            error_count = 0;
   bit            stim_done = 1'b0;
   bit            hold_off = 1'b0;
   stim_row_type  rows[$];

   circle_contact_penalty_force u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v -= res + bit_w;
            res = (res >> 1) + bit_w;
         end else begin
            res >>= 1;
         end
         bit_w >>= 2;
      end
      return res;
   endfunction

   function automatic longint axis_force(logic [63:0] mag, longint d, logic [63:0] len);
      logic [63:0] ad, q;
      ad = (d < 0) ? -d : d;
      q = (mag * ad * 256 + (len >> 1)) / len;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic rsp_word_type contact_force(req_word_type w, logic [15:0] k);
      rsp_word_type r;
      longint dx, dy, fx, fy;
      logic [63:0] d2, rs, len, depth, mn, mag;
      dx = longint'(w.a_x) - longint'(w.b_x);
      dy = longint'(w.a_y) - longint'(w.b_y);
      d2 = dx * dx + dy * dy;
      rs = 64'(w.a_radius) + 64'(w.b_radius);
      fx = 0;
      fy = 0;
      r.contact = d2 < rs * rs;
      if (r.contact && d2 != 0) begin
         len = int_sqrt(d2 << 16);
         depth = (rs << 8) - len;
         mn = (w.a_radius < w.b_radius) ? 64'(w.a_radius) : 64'(w.b_radius);
         mag = (depth * k * mn + (64'd1 << 31)) >> 32;
         fx = axis_force(mag, dx, len);
         fy = axis_force(mag, dy, len);
      end
      r.force_a_x = w.a_fixed ? 0 : fx[31:0];
      r.force_a_y = w.a_fixed ? 0 : fy[31:0];
      r.force_b_x = w.b_fixed ? 0 : 32'(-fx);
      r.force_b_y = w.b_fixed ? 0 : 32'(-fy);
      return r;
   endfunction

   function automatic int gap_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
   endfunction

   function automatic req_word_type pair_word(int ax, int ay, int ar, bit af,
                                               int bx, int by, int br, bit bf);
      req_word_type w;
      w.a_x = 24'(ax); w.a_y = 24'(ay); w.a_radius = 16'(ar); w.a_fixed = af;
      w.b_x = 24'(bx); w.b_y = 24'(by); w.b_radius = 16'(br); w.b_fixed = bf;
      return w;
   endfunction

   function automatic req_word_type random_pair();
      req_word_type w;
      int span;
      w = 146'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 9) < 8) begin
         // near pair, mostly in contact
         span = (w.a_radius + w.b_radius + 2) * 3 / 4;
         w.b_x = 24'(w.a_x + $signed($urandom_range(0, 2 * span)) - span);
         w.b_y = 24'(w.a_y + $signed($urandom_range(0, 2 * span)) - span);
      end
      return w;
   endfunction

   task automatic send_word(req_word_type w);
      int gap;
      gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word <= w;
      req_valid <= 1'b1;
      force_queue.push_back(contact_force(w, stiffness_model));
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_and_write(logic [15:0] k);
      req_valid <= 1'b0;
      while (force_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= k;
      stiffness_model = k;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (force_queue.size() == 0) begin
            $error("unexpected word %h", rsp_word);
            error_count++;
         end else begin
            e = force_queue.pop_front();
            if (rsp_word.contact !== e.contact) begin
               $error("contact exp %0d got %0d", e.contact, rsp_word.contact);
               error_count++;
            end
            if (rsp_word.force_a_x !== e.force_a_x) begin
               $error("force_a_x exp %0d got %0d", e.force_a_x, rsp_word.force_a_x);
               error_count++;
            end
            if (rsp_word.force_a_y !== e.force_a_y) begin
               $error("force_a_y exp %0d got %0d", e.force_a_y, rsp_word.force_a_y);
               error_count++;
            end
            if (rsp_word.force_b_x !== e.force_b_x) begin
               $error("force_b_x exp %0d got %0d", e.force_b_x, rsp_word.force_b_x);
               error_count++;
            end
            if (rsp_word.force_b_y !== e.force_b_y) begin
               $error("force_b_y exp %0d got %0d", e.force_b_y, rsp_word.force_b_y);
               error_count++;
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < 200; n++) @(negedge clock);
            hold_off = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (gap_len()) @(negedge clock);
            @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   initial begin
      int i;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows; expected words typed in where obvious
      rows.push_back('{pair_word(0, 0, 0, 0, 0, 0, 0, 0), 1, '0});
      rows.push_back('{pair_word(1000, 0, 256, 0, 0, 0, 256, 0), 1, '0});
      rows.push_back('{pair_word(5, 5, 256, 0, 5, 5, 256, 0), 1, {1'b1, 128'd0}});
      rows.push_back('{pair_word(-8388608, -8388608, 65535, 1, 8388607, 8388607, 65535, 1),
                       1, '0});
      rows.push_back('{pair_word(0, 0, 256, 0, 256, 0, 256, 0), 0, '0});
      rows.push_back('{pair_word(0, 0, 256, 1, 256, 0, 256, 0), 0, '0});
      rows.push_back('{pair_word(0, 0, 256, 0, 0, 256, 256, 1), 0, '0});
      rows.push_back('{pair_word(0, 0, 65535, 0, 1, 0, 65535, 0), 0, '0});
      rows.push_back('{pair_word(8388607, 8388607, 65535, 0, 8388500, 8388400, 65535, 0),
                       0, '0});
      rows.push_back('{pair_word(-8388608, -8388608, 65535, 0, -8388000, -8388100, 65535, 0),
                       0, '0});
      rows.push_back('{pair_word(0, 0, 65535, 0, -90000, 90000, 65535, 0), 0, '0});
      rows.push_back('{pair_word(0, 0, 0, 0, 1, 0, 300, 0), 0, '0});
      rows.push_back('{pair_word(0, 0, 1, 0, 1, 1, 1, 0), 0, '0});
      rows.push_back('{pair_word(100, -100, 500, 1, -100, 100, 500, 1), 0, '0});
      rows.push_back('{pair_word(3, 0, 2, 0, 0, 0, 2, 0), 0, '0});
      foreach (rows[i]) begin
         send_word(rows[i].word);
         if (rows[i].has_expect)
            force_queue[force_queue.size() - 1] = rows[i].expect_word;
      end

      drain_and_write(16'hFFFF);
      for (i = 0; i < 180; i++) begin
         if (i == 20) hold_off = 1'b1;
         send_word(random_pair());
      end
      drain_and_write(16'd0);
      for (i = 0; i < 60; i++) send_word(random_pair());
      drain_and_write(16'd1);
      for (i = 0; i < 60; i++) send_word(random_pair());
      drain_and_write(16'($urandom));
      for (i = 0; i < 150; i++) send_word(random_pair());
      drain_and_write(STIFF_RESET);
      for (i = 0; i < 100; i++) send_word(random_pair());

      req_valid <= 1'b0;
      while (force_queue.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0)
         $display("circle_contact_penalty_force test passed");
      else
         $display("circle_contact_penalty_force test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("circle_contact_penalty_force test failed");
      $finish;
   end

endmodule

`default_nettype wire
